### rtl/core/rgbhsv_pkg.sv
package rgbhsv_pkg;

   // field widths
   localparam int CHAN_W    = 8;
   localparam int HUE_W     = 7;
   localparam int SAT_NUM_W = 16;
   localparam int HUE_NUM_W = 13;
   localparam int HUE_Q_W   = 5;

   // one quotient bit per divider step
   localparam int DIV_STEPS = 8;

   // queue between the front and back parts
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // hue wheel constants
   localparam logic [HUE_NUM_W-1:0] HUE_STEP   = 13'd23;
   localparam logic [HUE_W-1:0]     BASE_RED   = 7'd0;
   localparam logic [HUE_W-1:0]     BASE_GREEN = 7'd43;
   localparam logic [HUE_W-1:0]     BASE_BLUE  = 7'd86;
   localparam logic [HUE_W-1:0]     WHEEL      = 7'd127;

   // classified pixel, as handed from the front part to the back part
   typedef struct packed {
      logic [CHAN_W-1:0]    bright;
      logic [SAT_NUM_W-1:0] sat_num;
      logic [CHAN_W-1:0]    sat_den;
      logic [HUE_NUM_W-1:0] hue_num;
      logic [CHAN_W-1:0]    hue_den;
      logic [HUE_W-1:0]     base;
      logic                 neg;
   } job_type;

   // divider stage contents: numerators turn into partial remainders
   typedef struct packed {
      job_type             job;
      logic [CHAN_W-1:0]   sat_q;
      logic [HUE_Q_W-1:0]  hue_q;
   } div_type;

endpackage

### rtl/core/rgbhsv_front.sv
module rgbhsv_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [rgbhsv_pkg::CHAN_W-1:0] req_red,
   input  logic [rgbhsv_pkg::CHAN_W-1:0] req_green,
   input  logic [rgbhsv_pkg::CHAN_W-1:0] req_blue,
   output logic                          job_valid,
   output rgbhsv_pkg::job_type           job,
   input  logic                          job_ready
);
   import rgbhsv_pkg::*;

   logic              valid_ff, valid_in;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;
   logic [CHAN_W-1:0] hi, lo, rng, pos, negv, diff;
   logic              take;

   // input register: holds while the queue is full
   assign req_full  = valid_ff && !job_ready;
   assign take      = req_push && !req_full;
   assign job_valid = valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (!req_full) begin
         valid_in = req_push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
      end
   end

   // classify: extremes, sector, signed difference
   always_comb begin
      hi = red_ff;
      lo = red_ff;
      if (green_ff > hi) hi = green_ff;
      if (blue_ff > hi)  hi = blue_ff;
      if (green_ff < lo) lo = green_ff;
      if (blue_ff < lo)  lo = blue_ff;
      rng = hi - lo;

      // ties go to red, then green
      if (hi == red_ff) begin
         job.base = BASE_RED;
         pos      = green_ff;
         negv     = blue_ff;
      end else if (hi == green_ff) begin
         job.base = BASE_GREEN;
         pos      = blue_ff;
         negv     = red_ff;
      end else begin
         job.base = BASE_BLUE;
         pos      = red_ff;
         negv     = green_ff;
      end

      job.neg = (pos < negv);
      diff    = job.neg ? (negv - pos) : (pos - negv);

      job.bright  = hi;
      // 255 * range
      job.sat_num = {rng, 8'd0} - {8'd0, rng};
      job.hue_num = HUE_NUM_W'(diff) * HUE_STEP;
      // black and grey pixels have a zero numerator; a unit divisor then
      // gives a zero quotient without any special case downstream
      job.sat_den = (hi == '0)  ? CHAN_W'(1) : hi;
      job.hue_den = (rng == '0) ? CHAN_W'(1) : rng;
   end

endmodule

### rtl/core/rgbhsv_queue.sv
module rgbhsv_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rgbhsv_pkg::job_type push_job,
   output logic                full,
   input  logic                pop,
   output rgbhsv_pkg::job_type pop_job,
   output logic                empty
);
   import rgbhsv_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   // pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + (QUEUE_AW+1)'(1)))
      else $error("queue count missed a push");

endmodule

### rtl/core/rgbhsv_back.sv
module rgbhsv_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  rgbhsv_pkg::job_type           job,
   output logic                          job_pop,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output logic [rgbhsv_pkg::HUE_W-1:0]  rsp_hue,
   output logic [rgbhsv_pkg::CHAN_W-1:0] rsp_saturation,
   output logic [rgbhsv_pkg::CHAN_W-1:0] rsp_brightness
);
   import rgbhsv_pkg::*;

   div_type            stage_ff [DIV_STEPS+1];
   div_type            step_out [DIV_STEPS];
   logic [DIV_STEPS:0] valid_ff;
   logic [DIV_STEPS+1:0] rdy;
   logic               out_valid_ff;
   logic [HUE_W-1:0]   hue_ff, hue_in, mag;
   logic [CHAN_W-1:0]  sat_ff, bright_ff;

   // stall chain: a stage moves when empty or when the next one moves
   always_comb begin
      rdy[DIV_STEPS+1] = !out_valid_ff || rsp_pop;
      for (int k = DIV_STEPS; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   assign job_pop = job_valid && rdy[0];

   // stage 0 takes the queue head
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         valid_ff[0] <= job_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         stage_ff[0] <= {job, {CHAN_W{1'b0}}, {HUE_Q_W{1'b0}}};
      end
   end

   // restoring division, one quotient bit per stage, both dividers side by side
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int BIT = DIV_STEPS - 1 - k;

      logic [SAT_NUM_W-1:0] s_sub;
      logic [HUE_NUM_W-1:0] h_sub;
      logic                 s_take, h_take;
      logic [HUE_Q_W-1:0]   h_bit;

      assign s_sub  = SAT_NUM_W'(stage_ff[k].job.sat_den) << BIT;
      assign s_take = (stage_ff[k].job.sat_num >= s_sub);

      // hue quotient never exceeds 23, so only the low bits are worked
      if (BIT < HUE_Q_W) begin : g_hue
         assign h_sub  = HUE_NUM_W'(stage_ff[k].job.hue_den) << BIT;
         assign h_take = (stage_ff[k].job.hue_num >= h_sub);
         assign h_bit  = HUE_Q_W'(1) << BIT;
      end else begin : g_nohue
         assign h_sub  = '0;
         assign h_take = 1'b0;
         assign h_bit  = '0;
      end

      always_comb begin
         step_out[k] = stage_ff[k];
         if (s_take) begin
            step_out[k].job.sat_num = stage_ff[k].job.sat_num - s_sub;
            step_out[k].sat_q[BIT]  = 1'b1;
         end
         if (h_take) begin
            step_out[k].job.hue_num = stage_ff[k].job.hue_num - h_sub;
            step_out[k].hue_q       = stage_ff[k].hue_q | h_bit;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (rdy[k+1]) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k+1]) begin
            stage_ff[k+1] <= step_out[k];
         end
      end
   end

   // hue from sector base and magnitude, wrapped into the wheel
   always_comb begin
      mag = HUE_W'(stage_ff[DIV_STEPS].hue_q);
      if (!stage_ff[DIV_STEPS].job.neg) begin
         hue_in = stage_ff[DIV_STEPS].job.base + mag;
      end else if (mag > stage_ff[DIV_STEPS].job.base) begin
         hue_in = stage_ff[DIV_STEPS].job.base + WHEEL - mag;
      end else begin
         hue_in = stage_ff[DIV_STEPS].job.base - mag;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (rdy[DIV_STEPS+1]) begin
         out_valid_ff <= valid_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[DIV_STEPS+1]) begin
         hue_ff    <= hue_in;
         sat_ff    <= stage_ff[DIV_STEPS].sat_q;
         bright_ff <= stage_ff[DIV_STEPS].job.bright;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_brightness = bright_ff;

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (hue_ff != WHEEL))
      else $error("hue off the wheel");

   a_black_sat: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (bright_ff == '0)) |-> (sat_ff == '0 && hue_ff == '0))
      else $error("black pixel with hue or saturation");

endmodule

### rtl/core/rgb_to_hsv_unit.sv
// RGB to HSV converter, 8-bit channels, 127-step hue wheel.
// Input side is a queue: drive req_red/req_green/req_blue with req_push;
// a pixel transfers at a clock edge where req_push is high and req_full low.
// Result side is a queue too: while rsp_empty is low the oldest result sits on
// rsp_hue/rsp_saturation/rsp_brightness; it transfers on an edge with rsp_pop
// high. Every pixel gives exactly one result, in order.
// Path from input to result: input register, 4-entry queue, load stage,
// eight divider stages each producing one quotient bit, result register.
// Throughput: one pixel per clock while rsp_pop keeps results draining; the
// pipelined dividers take a new pair of operands every cycle unless stalled.
// When rsp_pop is held low the pipeline fills and then the queue; req_full
// rises once the input register can no longer drain. No result is dropped.
// Reset (synchronous, active high) empties the pipeline and the queue; no
// clearing pass is needed and the block takes pixels the cycle after reset.
module rgb_to_hsv_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [rgbhsv_pkg::CHAN_W-1:0] req_red,
   input  logic [rgbhsv_pkg::CHAN_W-1:0] req_green,
   input  logic [rgbhsv_pkg::CHAN_W-1:0] req_blue,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [rgbhsv_pkg::HUE_W-1:0]  rsp_hue,
   output logic [rgbhsv_pkg::CHAN_W-1:0] rsp_saturation,
   output logic [rgbhsv_pkg::CHAN_W-1:0] rsp_brightness
);
   import rgbhsv_pkg::*;

   job_type fr_job, q_job;
   logic    fr_valid, q_full, q_empty, q_pop;

   // front part: input register and classification
   rgbhsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .job_valid (fr_valid),
      .job       (fr_job),
      .job_ready (!q_full)
   );

   // decoupling queue
   rgbhsv_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fr_valid),
      .push_job (fr_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (q_job),
      .empty    (q_empty)
   );

   // back part: dividers and result register
   rgbhsv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (!q_empty),
      .job            (q_job),
      .job_pop        (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

endmodule
